// ===== rtl/rwps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwps_pkg: shared types and constants
// Field widths, command and status codes, and the control and status structs
// that join the controller and the datapath of the parent select unit.
// ----------------------------------------------------------------------------
package rwps_pkg;

    // Field widths fixed by the item formats.
    localparam int CMD_W     = 2;
    localparam int IDX_W     = 6;
    localparam int FIT_W     = 16;
    localparam int PICK_W    = 22;
    localparam int TOT_W     = 22;
    localparam int ST_W      = 2;
    localparam int GEN_W     = 32;
    localparam int SIZE_W    = 7;
    localparam int MAX_SIZE  = 64;

    // Default table depth.
    localparam int MEMBERS_DEF = 64;

    // Input commands.
    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE   = 2'd0,
        CMD_PICK    = 2'd1,
        CMD_END_GEN = 2'd2
    } cmd_t;

    // Result status codes.
    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_NO_PICK = 2'd2
    } status_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_DRAIN,
        S_DONE
    } state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic clear_wr;   // write zero at the walk counter (clearing pass)
        logic start;      // item accepted: latch it, do a fitness write if it is an in-range write
        logic issue;      // read the table entry at the walk counter
        logic load;       // move the finished result into the output register
    } ctl_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic last_clear; // counter sits on the last table entry
        logic last_issue; // counter sits on the last member in use
    } dp_status_t;

endpackage

// ===== rtl/rwps_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwps_if: item channels of the parent select unit
// Valid/ready channels for incoming commands and outgoing results.
// ----------------------------------------------------------------------------

// Command item channel.
interface rwps_item_if;
    logic                          valid;
    logic                          ready;
    logic [rwps_pkg::CMD_W-1:0]    cmd;
    logic [rwps_pkg::IDX_W-1:0]    member_index;
    logic [rwps_pkg::FIT_W-1:0]    fitness_value;
    logic [rwps_pkg::PICK_W-1:0]   spin_value;

    modport source (
        output valid, cmd, member_index, fitness_value, spin_value,
        input  ready
    );
    modport sink (
        input  valid, cmd, member_index, fitness_value, spin_value,
        output ready
    );
endinterface

// Result item channel.
interface rwps_result_if;
    logic                          valid;
    logic                          ready;
    logic [rwps_pkg::IDX_W-1:0]    picked_index;
    logic [rwps_pkg::ST_W-1:0]     status;
    logic [rwps_pkg::TOT_W-1:0]    fitness_total;
    logic [rwps_pkg::IDX_W-1:0]    fittest_index;
    logic [rwps_pkg::FIT_W-1:0]    fittest_value;
    logic [rwps_pkg::FIT_W-1:0]    best_of_generation;
    logic [rwps_pkg::FIT_W-1:0]    best_ever;
    logic [rwps_pkg::GEN_W-1:0]    generation_number;

    modport source (
        output valid, picked_index, status, fitness_total, fittest_index,
               fittest_value, best_of_generation, best_ever, generation_number,
        input  ready
    );
    modport sink (
        input  valid, picked_index, status, fitness_total, fittest_index,
               fittest_value, best_of_generation, best_ever, generation_number,
        output ready
    );
endinterface

// ===== rtl/rwps_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwps_ctrl: sequencing state machine
// Runs the clearing pass after reset, accepts one item at a time, steps the
// table walk and hands the result to the output register.
// ----------------------------------------------------------------------------
module rwps_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  rwps_pkg::dp_status_t  dp_status,
    output rwps_pkg::ctl_cmd_t    dp_cmd
);

    rwps_pkg::state_t state_reg;
    rwps_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    // State and output valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rwps_pkg::S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        dp_cmd     = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            rwps_pkg::S_CLEAR:
            begin
                dp_cmd.clear_wr = 1'b1;
                if (dp_status.last_clear)
                begin
                    state_next = rwps_pkg::S_IDLE;
                end
            end
            rwps_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    dp_cmd.start = 1'b1;
                    state_next   = rwps_pkg::S_READ;
                end
            end
            rwps_pkg::S_READ:
            begin
                dp_cmd.issue = 1'b1;
                if (dp_status.last_issue)
                begin
                    state_next = rwps_pkg::S_DRAIN;
                end
            end
            rwps_pkg::S_DRAIN:
            begin
                state_next = rwps_pkg::S_DONE;
            end
            rwps_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    dp_cmd.load = 1'b1;
                    state_next  = rwps_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rwps_pkg::S_IDLE;
            end
        endcase
    end

    // The output register holds its item until the consumer takes it.
    always_comb
    begin
        if (dp_cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/rwps_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwps_dpath: fitness table and walk datapath
// Holds the fitness memory, the latched item, the walk counter, the running
// total, fittest and pick accumulators, the generation records and the
// output payload register.
// ----------------------------------------------------------------------------
module rwps_dpath #(
    parameter int MEMBERS = rwps_pkg::MEMBERS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rwps_pkg::ctl_cmd_t            dp_cmd,
    output rwps_pkg::dp_status_t          dp_status,
    input  logic                          cfg_we,
    input  logic [rwps_pkg::SIZE_W-1:0]   cfg_wdata,
    input  logic [rwps_pkg::CMD_W-1:0]    item_cmd,
    input  logic [rwps_pkg::IDX_W-1:0]    item_index,
    input  logic [rwps_pkg::FIT_W-1:0]    item_fitness,
    input  logic [rwps_pkg::PICK_W-1:0]   item_pick,
    output logic [rwps_pkg::IDX_W-1:0]    picked_index,
    output logic [rwps_pkg::ST_W-1:0]     status,
    output logic [rwps_pkg::TOT_W-1:0]    fitness_total,
    output logic [rwps_pkg::IDX_W-1:0]    fittest_index,
    output logic [rwps_pkg::FIT_W-1:0]    fittest_value,
    output logic [rwps_pkg::FIT_W-1:0]    best_of_generation,
    output logic [rwps_pkg::FIT_W-1:0]    best_ever,
    output logic [rwps_pkg::GEN_W-1:0]    generation_number
);

    localparam int ADDR_W   = (MEMBERS > 1) ? $clog2(MEMBERS) : 1;
    localparam int CNT_W    = $clog2(MEMBERS + 1);
    localparam int EXT_W    = (CNT_W > rwps_pkg::SIZE_W) ? CNT_W : rwps_pkg::SIZE_W;
    localparam int SIZE_RST = (MEMBERS < rwps_pkg::MAX_SIZE) ? MEMBERS : rwps_pkg::MAX_SIZE;

    // Fitness memory.
    logic [rwps_pkg::FIT_W-1:0] fit_mem [MEMBERS];
    logic                       wr_en;
    logic [ADDR_W-1:0]          wr_addr;
    logic [rwps_pkg::FIT_W-1:0] wr_data;
    logic [rwps_pkg::FIT_W-1:0] rd_data_reg;

    // Configuration and walk control.
    logic [rwps_pkg::SIZE_W-1:0] pop_size_reg;
    logic [EXT_W-1:0]            size_ext;
    logic [CNT_W-1:0]            n_use;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        wr_ok;
    logic                        pipe_vld_reg;
    logic [ADDR_W-1:0]           pipe_idx_reg;

    // Latched item.
    rwps_pkg::cmd_t              cmd_reg;
    rwps_pkg::status_t           status_reg;

    // Walk accumulators.
    logic [rwps_pkg::TOT_W-1:0]  total_reg;
    logic [rwps_pkg::FIT_W-1:0]  best_val_reg;
    logic [ADDR_W-1:0]           best_idx_reg;
    logic [rwps_pkg::PICK_W-1:0] rem_reg;
    logic                        found_reg;
    logic [ADDR_W-1:0]           picked_reg;
    logic [rwps_pkg::PICK_W-1:0] fit_ext;
    logic                        pick_hit;

    // Generation records.
    logic [rwps_pkg::FIT_W-1:0]  best_gen_reg;
    logic [rwps_pkg::FIT_W-1:0]  best_all_reg;
    logic [rwps_pkg::GEN_W-1:0]  gen_reg;

    // Output payload register.
    logic [rwps_pkg::IDX_W-1:0]  out_picked_reg;
    rwps_pkg::status_t           out_status_reg;
    logic [rwps_pkg::TOT_W-1:0]  out_total_reg;
    logic [rwps_pkg::IDX_W-1:0]  out_fit_idx_reg;
    logic [rwps_pkg::FIT_W-1:0]  out_fit_val_reg;

    // Members in use: a size of zero acts as one, a size above the depth as the depth.
    always_comb
    begin
        size_ext = EXT_W'(pop_size_reg);
        if (size_ext == '0)
        begin
            n_use = CNT_W'(1);
        end
        else if (size_ext > EXT_W'(MEMBERS))
        begin
            n_use = CNT_W'(MEMBERS);
        end
        else
        begin
            n_use = CNT_W'(size_ext);
        end
    end

    assign wr_ok = (EXT_W'(item_index) < EXT_W'(n_use));

    // Walk counter status.
    assign dp_status.last_clear = (cnt_reg == CNT_W'(MEMBERS - 1));
    assign dp_status.last_issue = (cnt_reg == (n_use - CNT_W'(1)));

    // Size register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop_size_reg <= rwps_pkg::SIZE_W'(SIZE_RST);
        end
        else if (cfg_we)
        begin
            pop_size_reg <= cfg_wdata;
        end
    end

    // Memory write port: zeroes during the clearing pass, else a fitness write.
    always_comb
    begin
        wr_en   = dp_cmd.clear_wr
                  || (dp_cmd.start && (item_cmd == rwps_pkg::CMD_WRITE) && wr_ok);
        wr_addr = dp_cmd.clear_wr ? cnt_reg[ADDR_W-1:0] : ADDR_W'(item_index);
        wr_data = dp_cmd.clear_wr ? '0 : item_fitness;
    end

    // Fitness memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fit_mem[wr_addr] <= wr_data;
        end
        if (dp_cmd.issue)
        begin
            rd_data_reg <= fit_mem[cnt_reg[ADDR_W-1:0]];
        end
    end

    // Walk counter and read pipeline valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            pipe_vld_reg <= 1'b0;
        end
        else
        begin
            pipe_vld_reg <= dp_cmd.issue;
            if (dp_cmd.start)
            begin
                cnt_reg <= '0;
            end
            else if (dp_cmd.clear_wr || dp_cmd.issue)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    // Index of the entry in the read register.
    always_ff @(posedge clk)
    begin
        if (dp_cmd.issue)
        begin
            pipe_idx_reg <= cnt_reg[ADDR_W-1:0];
        end
    end

    // Pick test for the entry in the read register.
    assign fit_ext  = rwps_pkg::PICK_W'(rd_data_reg);
    assign pick_hit = (rem_reg <= fit_ext);

    // Item latch and walk accumulators.
    always_ff @(posedge clk)
    begin
        if (dp_cmd.start)
        begin
            cmd_reg      <= rwps_pkg::cmd_t'(item_cmd);
            status_reg   <= ((item_cmd == rwps_pkg::CMD_WRITE) && !wr_ok)
                            ? rwps_pkg::ST_RANGE : rwps_pkg::ST_OK;
            rem_reg      <= item_pick;
            total_reg    <= '0;
            best_val_reg <= '0;
            best_idx_reg <= '0;
            found_reg    <= 1'b0;
            picked_reg   <= '0;
        end
        else if (pipe_vld_reg)
        begin
            total_reg <= total_reg + rwps_pkg::TOT_W'(rd_data_reg);
            if (rd_data_reg > best_val_reg)
            begin
                best_val_reg <= rd_data_reg;
                best_idx_reg <= pipe_idx_reg;
            end
            if ((cmd_reg == rwps_pkg::CMD_PICK) && !found_reg)
            begin
                if (pick_hit)
                begin
                    found_reg  <= 1'b1;
                    picked_reg <= pipe_idx_reg;
                end
                else
                begin
                    rem_reg <= rem_reg - fit_ext;
                end
            end
        end
    end

    // Generation records update when a generation-end result is loaded.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_gen_reg <= '0;
            best_all_reg <= '0;
            gen_reg      <= rwps_pkg::GEN_W'(1);
        end
        else if (dp_cmd.load && (cmd_reg == rwps_pkg::CMD_END_GEN))
        begin
            best_gen_reg <= best_val_reg;
            if (best_val_reg > best_all_reg)
            begin
                best_all_reg <= best_val_reg;
            end
            gen_reg <= gen_reg + rwps_pkg::GEN_W'(1);
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
        begin
            out_picked_reg  <= ((cmd_reg == rwps_pkg::CMD_PICK) && found_reg)
                               ? rwps_pkg::IDX_W'(picked_reg) : '0;
            if ((cmd_reg == rwps_pkg::CMD_PICK) && !found_reg)
            begin
                out_status_reg <= rwps_pkg::ST_NO_PICK;
            end
            else
            begin
                out_status_reg <= status_reg;
            end
            out_total_reg   <= total_reg;
            out_fit_idx_reg <= rwps_pkg::IDX_W'(best_idx_reg);
            out_fit_val_reg <= best_val_reg;
        end
    end

    // The records change only when a result is loaded, so they drive the port directly.
    assign picked_index       = out_picked_reg;
    assign status             = out_status_reg;
    assign fitness_total      = out_total_reg;
    assign fittest_index      = out_fit_idx_reg;
    assign fittest_value      = out_fit_val_reg;
    assign best_of_generation = best_gen_reg;
    assign best_ever          = best_all_reg;
    assign generation_number  = gen_reg;

endmodule

// ===== rtl/roulette_wheel_parent_select_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roulette_wheel_parent_select_unit: fitness table with roulette-wheel pick
//
//   Channel   Role     Carries
//   items     sink     cmd, member_index, fitness_value, spin_value
//   results   source   picked_index, status, totals, fittest and records
//   cfg       write    population_size (cfg_we, cfg_wdata)
//
// Each item is accepted, then walks n reads of the fitness memory read port,
// n being the members in use, drains the read register and loads the output
// register. After reset a clearing pass zeroes every table entry before the
// first item is accepted. A result held in the output register does not
// block the next item; only loading the following result waits for the
// consumer.
// ----------------------------------------------------------------------------
module roulette_wheel_parent_select_unit #(
    parameter int MEMBERS = rwps_pkg::MEMBERS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    rwps_item_if.sink                   items,
    rwps_result_if.source               results,
    input  logic                        cfg_we,
    input  logic [rwps_pkg::SIZE_W-1:0] cfg_wdata
);

    rwps_pkg::ctl_cmd_t   dp_cmd;
    rwps_pkg::dp_status_t dp_status;

    // Sequencer.
    rwps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (items.valid),
        .in_ready  (items.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    // Table and arithmetic.
    rwps_dpath #(
        .MEMBERS (MEMBERS)
    ) u_dpath (
        .clk                (clk),
        .rst_n              (rst_n),
        .dp_cmd             (dp_cmd),
        .dp_status          (dp_status),
        .cfg_we             (cfg_we),
        .cfg_wdata          (cfg_wdata),
        .item_cmd           (items.cmd),
        .item_index         (items.member_index),
        .item_fitness       (items.fitness_value),
        .item_pick          (items.spin_value),
        .picked_index       (results.picked_index),
        .status             (results.status),
        .fitness_total      (results.fitness_total),
        .fittest_index      (results.fittest_index),
        .fittest_value      (results.fittest_value),
        .best_of_generation (results.best_of_generation),
        .best_ever          (results.best_ever),
        .generation_number  (results.generation_number)
    );

`ifndef SYNTH
    // One item at a time: no new item right after an accept.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (items.valid && items.ready) |=> !items.ready)
        else $error("item accepted while another is in flight");

    // A loaded result is presented on the next cycle.
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.load |=> results.valid)
        else $error("loaded result not presented");

    // The overall record never falls below the last generation record.
    a_best_order: assert property (@(posedge clk) disable iff (!rst_n)
        results.best_ever >= results.best_of_generation)
        else $error("best ever below best of generation");

    // A failed or ignored command reports no picked member.
    a_pick_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && (results.status != rwps_pkg::ST_OK))
            |-> (results.picked_index == '0))
        else $error("picked index set on a failing status");
`endif

endmodule
